[rtl/mtc_pkg.sv]
// Shared constants, types and blend helpers for the marker tag cache.
package mtc_pkg;

    localparam int ENTRIES   = 12;
    localparam int ICON_BITS = 8;
    localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int COLOR_W   = 24;
    localparam int ICON_IN_W = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int NUM_W     = 15;
    localparam int RECIP_W   = 13;
    localparam int PROD_W    = NUM_W + RECIP_W;

    // x / 100 == (x * 5243) >> 19 for every x below 43690
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int                 RECIP_SH  = 19;

    localparam logic [7:0] FILL_PCT    = 8'd28;
    localparam logic [7:0] OUTLINE_PCT = 8'd55;
    localparam logic [7:0] FILL_R      = 8'd26;
    localparam logic [7:0] FILL_G      = 8'd24;
    localparam logic [7:0] FILL_B      = 8'd22;
    localparam logic [7:0] OUTLINE_R   = 8'd34;
    localparam logic [7:0] OUTLINE_G   = 8'd28;
    localparam logic [7:0] OUTLINE_B   = 8'd24;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    typedef logic [NUM_W-1:0] num_t;

    // numerator c*(100-p) + k*p, at most 15 bits for 8-bit channels
    function automatic num_t blend_num(input logic [7:0] c, input logic [7:0] k,
                                       input logic [7:0] p);
        logic [15:0] a;
        logic [15:0] b;
        a = 16'(c) * 16'(8'd100 - p);
        b = 16'(k) * 16'(p);
        return NUM_W'(a + b);
    endfunction

    function automatic logic [7:0] div100(input num_t x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP_100);
        return 8'(prod >> RECIP_SH);
    endfunction

endpackage

[rtl/marker_tag_cache_round_robin_top.sv]
// Marker tag cache top level: stream ports, sequencer and datapath.
// Flow: a request is accepted in idle, looked up in the lookup state and its result is held in send
// until accepted; the sequencer holds one request at a time through lookup and delivery,
// so no new request is accepted until the result has been taken.
// Reset: aresetn low clears all valid bits, the victim pointer and the sequencer;
// tag contents and result registers carry no reset.
module marker_tag_cache_round_robin_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // marker_color[23:0], icon_id[31:24]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // slot[3:0], fill_color[27:4], outline_color[51:28], zero[55:52]
    output logic [0:0]  m_tuser    // hit[0]
);
    import mtc_pkg::*;

    cmd_t                  cmd;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COLOR_W-1:0]    fill_color;
    logic [COLOR_W-1:0]    outline_color;

    mtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mtc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .req_type      (s_tuser[0]),
        .marker_color  (s_tdata[23:0]),
        .icon_id       (s_tdata[31:24]),
        .hit           (hit),
        .slot          (slot),
        .fill_color    (fill_color),
        .outline_color (outline_color)
    );

    assign m_tdata = {4'd0, outline_color, fill_color, slot};
    assign m_tuser = hit;

endmodule

[rtl/mtc_ctrl.sv]
// Request sequencer: accept, lookup and result delivery.
module mtc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mtc_pkg::cmd_t cmd
);
    import mtc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_LOOKUP: begin
                cmd.exec = 1'b1;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/mtc_dp.sv]
// Tag store, match logic, victim pointer and color blend datapath.
module mtc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mtc_pkg::cmd_t                     cmd,
    input  logic                              req_type,
    input  logic [mtc_pkg::COLOR_W-1:0]       marker_color,
    input  logic [mtc_pkg::ICON_IN_W-1:0]     icon_id,
    output logic                              hit,
    output logic [mtc_pkg::SLOT_OUT_W-1:0]    slot,
    output logic [mtc_pkg::COLOR_W-1:0]       fill_color,
    output logic [mtc_pkg::COLOR_W-1:0]       outline_color
);
    import mtc_pkg::*;

    logic                 req_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [ICON_BITS-1:0] icon_reg;
    num_t                 fnum_reg [3];
    num_t                 onum_reg [3];

    logic [ENTRIES-1:0]   valid_reg;
    logic [COLOR_W-1:0]   tag_color_reg [ENTRIES];
    logic [ICON_BITS-1:0] tag_icon_reg  [ENTRIES];
    logic [SLOT_W-1:0]    ptr_reg;
    logic [SLOT_W-1:0]    ptr_next;

    logic                  hit_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [COLOR_W-1:0]    fill_reg;
    logic [COLOR_W-1:0]    outline_reg;

    logic [ENTRIES-1:0]   match;
    logic                 any_hit;
    logic [SLOT_W-1:0]    hit_idx;
    logic [SLOT_W-1:0]    use_idx;
    logic [COLOR_W-1:0]   fill_calc;
    logic [COLOR_W-1:0]   outline_calc;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= req_type;
            color_reg   <= marker_color;
            icon_reg    <= ICON_BITS'(icon_id);
            fnum_reg[0] <= blend_num(marker_color[7:0],   FILL_R, FILL_PCT);
            fnum_reg[1] <= blend_num(marker_color[15:8],  FILL_G, FILL_PCT);
            fnum_reg[2] <= blend_num(marker_color[23:16], FILL_B, FILL_PCT);
            onum_reg[0] <= blend_num(marker_color[7:0],   OUTLINE_R, OUTLINE_PCT);
            onum_reg[1] <= blend_num(marker_color[15:8],  OUTLINE_G, OUTLINE_PCT);
            onum_reg[2] <= blend_num(marker_color[23:16], OUTLINE_B, OUTLINE_PCT);
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (tag_color_reg[i] == color_reg)
                       && (tag_icon_reg[i] == icon_reg);
        end
    end

    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                any_hit = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign use_idx  = any_hit ? hit_idx : ptr_reg;
    assign ptr_next = (ptr_reg == SLOT_W'(ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;

    assign fill_calc    = {div100(fnum_reg[2]), div100(fnum_reg[1]), div100(fnum_reg[0])};
    assign outline_calc = {div100(onum_reg[2]), div100(onum_reg[1]), div100(onum_reg[0])};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else if (cmd.exec) begin
            if (req_reg == REQ_CLEAR) begin
                valid_reg <= '0;
                ptr_reg   <= '0;
            end else if (!any_hit) begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && (req_reg == REQ_LOOKUP) && !any_hit) begin
            tag_color_reg[ptr_reg] <= color_reg;
            tag_icon_reg[ptr_reg]  <= icon_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (req_reg == REQ_CLEAR) begin
                hit_reg     <= 1'b0;
                slot_reg    <= '0;
                fill_reg    <= '0;
                outline_reg <= '0;
            end else begin
                hit_reg     <= any_hit;
                slot_reg    <= SLOT_OUT_W'(use_idx);
                fill_reg    <= fill_calc;
                outline_reg <= outline_calc;
            end
        end
    end

    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign fill_color    = fill_reg;
    assign outline_color = outline_reg;

endmodule

[test/testbench.sv]
// Self-checking testbench for the marker tag cache: directed table, then pooled random requests.
module testbench;
    import mtc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 100;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [COLOR_W-1:0]    fill;
        logic [COLOR_W-1:0]    outline;
    } marker_res_t;

    typedef struct {
        logic               req;
        logic [COLOR_W-1:0] color;
        logic [7:0]         icon;
        bit                 typed;
        marker_res_t        want;
    } marker_req_t;

    localparam marker_res_t NO_RESULT = '0;
    localparam logic [COLOR_W-1:0] BLACK_FILL    = 24'h060607;
    localparam logic [COLOR_W-1:0] BLACK_OUTLINE = 24'h0D0F12;
    localparam logic [COLOR_W-1:0] WHITE_FILL    = 24'hBDBEBE;
    localparam logic [COLOR_W-1:0] WHITE_OUTLINE = 24'h7F8285;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;

    marker_req_t        request_q[$];
    marker_res_t        pending_q[$];
    int                 err_cnt = 0;
    int                 cycle_cnt = 0;
    bit                 calm = 1'b0;
    bit                 hold_request = 1'b0;

    logic               tag_valid[ENTRIES];
    logic [COLOR_W-1:0] tag_color[ENTRIES];
    logic [7:0]         tag_icon[ENTRIES];
    int                 victim_ptr;

    marker_tag_cache_round_robin_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic logic [7:0] mix_channel(int c, int k, int p);
        return 8'((c * (100 - p) + k * p) / 100);
    endfunction

    function automatic logic [COLOR_W-1:0] mix_color(logic [COLOR_W-1:0] color,
                                                     int kr, int kg, int kb, int p);
        return {mix_channel(int'(color[23:16]), kb, p),
                mix_channel(int'(color[15:8]), kg, p),
                mix_channel(int'(color[7:0]), kr, p)};
    endfunction

    function automatic marker_res_t cache_predict(logic req, logic [COLOR_W-1:0] color,
                                                  logic [7:0] icon);
        marker_res_t res;
        int          found;
        res = '0;
        found = -1;
        if (req == REQ_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) tag_valid[i] = 1'b0;
            victim_ptr = 0;
            return res;
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (tag_valid[i] && tag_color[i] == color && tag_icon[i] == icon) found = i;
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            res.slot = SLOT_OUT_W'(found);
        end else begin
            tag_valid[victim_ptr] = 1'b1;
            tag_color[victim_ptr] = color;
            tag_icon[victim_ptr] = icon;
            res.slot = SLOT_OUT_W'(victim_ptr);
            victim_ptr = (victim_ptr + 1 >= ENTRIES) ? 0 : victim_ptr + 1;
        end
        res.fill = mix_color(color, 26, 24, 22, 28);
        res.outline = mix_color(color, 34, 28, 24, 55);
        return res;
    endfunction

    function automatic void add_row(logic req, logic [COLOR_W-1:0] color, logic [7:0] icon,
                                    bit typed, marker_res_t want);
        marker_req_t row;
        row.req = req;
        row.color = color;
        row.icon = icon;
        row.typed = typed;
        row.want = want;
        request_q.push_back(row);
    endfunction

    function automatic void build_stimulus();
        logic [COLOR_W-1:0] pool_color[16];
        logic [7:0]         pool_icon[16];
        logic [COLOR_W-1:0] color;
        logic [7:0]         icon;
        int                 roll;
        int                 k;
        add_row(REQ_LOOKUP, 24'h000000, 8'h00, 1, {1'b0, 4'd0, BLACK_FILL, BLACK_OUTLINE});
        add_row(REQ_LOOKUP, 24'h000000, 8'h00, 1, {1'b1, 4'd0, BLACK_FILL, BLACK_OUTLINE});
        add_row(REQ_LOOKUP, 24'hFFFFFF, 8'hFF, 1, {1'b0, 4'd1, WHITE_FILL, WHITE_OUTLINE});
        add_row(REQ_LOOKUP, 24'hFFFFFF, 8'hFE, 0, NO_RESULT);
        add_row(REQ_LOOKUP, 24'hFFFFFF, 8'hFF, 1, {1'b1, 4'd1, WHITE_FILL, WHITE_OUTLINE});
        for (int i = 0; i < 9; i++) begin
            add_row(REQ_LOOKUP, 24'h0F0000 + COLOR_W'(i * 24'h010101), 8'(8'h10 + i), 0,
                    NO_RESULT);
        end
        add_row(REQ_LOOKUP, 24'h7FFFFF, 8'h7F, 0, NO_RESULT);
        add_row(REQ_LOOKUP, 24'h000000, 8'h00, 0, NO_RESULT);
        add_row(REQ_LOOKUP, 24'hFFFFFF, 8'hFF, 0, NO_RESULT);
        add_row(REQ_CLEAR, 24'hFFFFFF, 8'hFF, 1, NO_RESULT);
        add_row(REQ_LOOKUP, 24'hFFFFFF, 8'hFF, 1, {1'b0, 4'd0, WHITE_FILL, WHITE_OUTLINE});
        add_row(REQ_CLEAR, 24'h000000, 8'h00, 1, NO_RESULT);
        add_row(REQ_CLEAR, 24'h123456, 8'h5A, 1, NO_RESULT);
        add_row(REQ_LOOKUP, 24'h800000, 8'h80, 0, NO_RESULT);
        add_row(REQ_LOOKUP, 24'h000080, 8'h01, 0, NO_RESULT);

        for (int i = 0; i < 16; i++) begin
            pool_color[i] = (i % 2 == 1) ? pool_color[i-1] : COLOR_W'($urandom);
            pool_icon[i] = 8'($urandom);
        end
        for (int n = 0; n < 450; n++) begin
            roll = $urandom_range(0, 99);
            k = $urandom_range(0, 15);
            color = pool_color[k];
            icon = pool_icon[k];
            if ($urandom_range(0, 99) < 5) begin
                pool_color[k] = COLOR_W'($urandom);
                pool_icon[k] = 8'($urandom);
            end
            if (roll < 4) begin
                add_row(REQ_CLEAR, COLOR_W'($urandom), 8'($urandom), 0, NO_RESULT);
            end else if (roll < 74) begin
                add_row(REQ_LOOKUP, color, icon, 0, NO_RESULT);
            end else if (roll < 84) begin
                if ($urandom_range(0, 1) == 0) color[$urandom_range(0, COLOR_W - 1)] ^= 1'b1;
                else icon[$urandom_range(0, 7)] ^= 1'b1;
                add_row(REQ_LOOKUP, color, icon, 0, NO_RESULT);
            end else begin
                add_row(REQ_LOOKUP, COLOR_W'($urandom), 8'($urandom), 0, NO_RESULT);
            end
        end
    endfunction

    initial begin
        marker_res_t want;
        for (int i = 0; i < ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_color[i] = '0;
            tag_icon[i] = '0;
        end
        victim_ptr = 0;
        build_stimulus();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (int n = 0; n < request_q.size(); n++) begin
            calm = (n >= 250 && n < 330);
            if (n == 120) hold_request = 1'b1;
            s_tvalid <= 1'b1;
            s_tuser <= request_q[n].req;
            s_tdata <= {request_q[n].icon, request_q[n].color};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            want = cache_predict(request_q[n].req, request_q[n].color, request_q[n].icon);
            if (request_q[n].typed) want = request_q[n].want;
            pending_q.push_back(want);
            if (!calm && $urandom_range(0, 99) < 24) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(0, 99) < 40);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    always @(posedge aclk) begin
        marker_res_t got;
        marker_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser[0];
            got.slot = m_tdata[3:0];
            got.fill = m_tdata[27:4];
            got.outline = m_tdata[51:28];
            if (pending_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected result: hit=%0d slot=%0d fill=%06h outline=%06h",
                             got.hit, got.slot, got.fill, got.outline);
                end
            end else begin
                want = pending_q.pop_front();
                if (got.hit !== want.hit || got.slot !== want.slot ||
                    got.fill !== want.fill || got.outline !== want.outline) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: expected hit=%0d slot=%0d fill=%06h outline=%06h",
                                 want.hit, want.slot, want.fill, want.outline);
                        $display("          actual   hit=%0d slot=%0d fill=%06h outline=%06h",
                                 got.hit, got.slot, got.fill, got.outline);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
